FILE: src/sm3_hash_engine_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef SM3_HASH_ENGINE_UNIT_MACROS_SVH
`define SM3_HASH_ENGINE_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SM3_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define SM3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: src/sm3_pkg.sv
// Package with SM3 constants, types and helper functions.
`default_nettype none
package sm3_pkg;
   localparam logic [31:0] IV_0 = 32'h7380166F;
   localparam logic [31:0] IV_1 = 32'h4914B2B9;
   localparam logic [31:0] IV_2 = 32'h172442D7;
   localparam logic [31:0] IV_3 = 32'hDA8A0600;
   localparam logic [31:0] IV_4 = 32'hA96F30BC;
   localparam logic [31:0] IV_5 = 32'h163138AA;
   localparam logic [31:0] IV_6 = 32'hE38DEE4D;
   localparam logic [31:0] IV_7 = 32'hB0FB0E4E;
   localparam logic [31:0] T_LOW = 32'h79CC4519;
   localparam logic [31:0] T_HIGH = 32'h7A879D8A;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PACK, ST_PAD, ST_LEN, ST_LOAD, ST_COMP, ST_FOLD, ST_EMIT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_word;   // latch the accepted word
      logic       put_data;    // write the next data byte
      logic       put_pad;     // write pad or zero byte at fill
      logic       pad_mark;    // the pad byte written is the 0x80 marker
      logic       put_len;     // write length words
      logic       clear_blk;   // zero the block buffer
      logic       comp_start;  // load round registers
      logic       comp_round;  // run one round
      logic       comp_final;  // fold result into chaining value
      logic       reinit;      // back to IV, clear counts
      logic [2:0] emit_idx;    // digest word selected
   } dp_cmd_type;

   // Status from the datapath.
   typedef struct packed {
      logic       bytes_left;  // data bytes of the word still to pack
      logic [5:0] fill;        // current byte fill
      logic       last_round;  // round counter at 63
      logic       last_flag;   // latched last flag
   } dp_sts_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] iv_word(input logic [2:0] i);
      logic [31:0] r;
      case (i)
         3'd0: r = IV_0;
         3'd1: r = IV_1;
         3'd2: r = IV_2;
         3'd3: r = IV_3;
         3'd4: r = IV_4;
         3'd5: r = IV_5;
         3'd6: r = IV_6;
         default: r = IV_7;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

FILE: src/sm3_if.sv
// Valid/ready stream interfaces for request and response channels.
`default_nettype none
interface sm3_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  valid_bytes;
   logic        last_word;
   modport source (output valid, data_word, valid_bytes, last_word, input ready);
   modport sink (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        digest_done;
   modport source (output valid, digest_word, word_index, digest_done, input ready);
   modport sink (input valid, digest_word, word_index, digest_done, output ready);
endinterface
`default_nettype wire

FILE: src/sm3_datapath.sv
// SM3 datapath: block buffer, counters, expansion window and round logic.
`default_nettype none
module sm3_datapath (
   input  wire                      clock,
   input  wire                      reset,
   input  wire [31:0]               req_data_word,
   input  wire [2:0]                req_valid_bytes,
   input  wire                      req_last_word,
   input  wire sm3_pkg::dp_cmd_type cmd,
   output sm3_pkg::dp_sts_type      sts,
   output logic [31:0]              digest_out
);
   import sm3_pkg::*;

   logic [31:0] blk_ff [16];
   logic [31:0] cv_ff [8];
   logic [31:0] cv_in [8];
   logic [31:0] st_ff [8];
   logic [31:0] st_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] word_ff;
   logic [2:0]  cnt_ff, cnt_in;
   logic [1:0]  pos_ff, pos_in;
   logic        last_ff;
   logic [5:0]  rnd_ff, rnd_in;

   // Byte to write and its location.
   logic [7:0]  wbyte;
   logic [3:0]  widx;
   logic [4:0]  wsh;
   logic [31:0] wexp, a12, ss1, ss2, ff_v, gg_v, tt1, tt2, tj;
   logic        low_rnd;

   // Padding writes the 0x80 marker once, then zeros.
   always_comb begin
      wbyte = cmd.pad_mark ? PAD_BYTE : 8'h00;
      widx = fill_ff[5:2];
      wsh = 5'd24 - {fill_ff[1:0], 3'b000};
   end

   // Round function on the working registers.
   always_comb begin
      low_rnd = (rnd_ff < 6'd16);
      tj = low_rnd ? T_LOW : T_HIGH;
      a12 = rotl(st_ff[0], 5'd12);
      ss1 = rotl(a12 + st_ff[4] + rotl(tj, rnd_ff[4:0]), 5'd7);
      ss2 = ss1 ^ a12;
      ff_v = low_rnd ? (st_ff[0] ^ st_ff[1] ^ st_ff[2])
           : ((st_ff[0] & st_ff[1]) | (st_ff[0] & st_ff[2]) | (st_ff[1] & st_ff[2]));
      gg_v = low_rnd ? (st_ff[4] ^ st_ff[5] ^ st_ff[6])
           : ((st_ff[4] & st_ff[5]) | (~st_ff[4] & st_ff[6]));
      tt1 = ff_v + st_ff[3] + ss2 + (w_ff[0] ^ w_ff[4]);
      tt2 = gg_v + st_ff[7] + ss1 + w_ff[0];
      wexp = w_ff[0] ^ w_ff[7] ^ rotl(w_ff[13], 5'd15);
      wexp = wexp ^ rotl(wexp, 5'd15) ^ rotl(wexp, 5'd23)
           ^ rotl(w_ff[3], 5'd7) ^ w_ff[10];
   end

   // Next state of registers.
   always_comb begin
      fill_in = fill_ff;
      len_in = len_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      rnd_in = rnd_ff;
      st_in = st_ff;
      w_in = w_ff;
      cv_in = cv_ff;
      if (cmd.load_word) begin
         cnt_in = (req_valid_bytes > 3'd4) ? 3'd4 : req_valid_bytes;
         pos_in = 2'd0;
      end
      if (cmd.put_data) begin
         fill_in = fill_ff + 6'd1;
         len_in = len_ff + 64'd8;
         cnt_in = cnt_ff - 3'd1;
         pos_in = pos_ff + 2'd1;
      end
      if (cmd.put_pad) fill_in = fill_ff + 6'd1;
      if (cmd.comp_start) begin
         st_in = cv_ff;
         w_in = blk_ff;
         rnd_in = 6'd0;
      end
      if (cmd.comp_round) begin
         st_in[0] = tt1;
         st_in[1] = st_ff[0];
         st_in[2] = rotl(st_ff[1], 5'd9);
         st_in[3] = st_ff[2];
         st_in[4] = tt2 ^ rotl(tt2, 5'd9) ^ rotl(tt2, 5'd17);
         st_in[5] = st_ff[4];
         st_in[6] = rotl(st_ff[5], 5'd19);
         st_in[7] = st_ff[6];
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = wexp;
         rnd_in = rnd_ff + 6'd1;
      end
      if (cmd.comp_final) begin
         for (int i = 0; i < 8; i++) cv_in[i] = cv_ff[i] ^ st_ff[i];
      end
      if (cmd.reinit) begin
         for (int i = 0; i < 8; i++) cv_in[i] = iv_word(3'(i));
         fill_in = 6'd0;
         len_in = 64'd0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 6'd0;
         len_ff <= 64'd0;
         cnt_ff <= 3'd0;
         pos_ff <= 2'd0;
         rnd_ff <= 6'd0;
         for (int i = 0; i < 8; i++) cv_ff[i] <= iv_word(3'(i));
      end else begin
         fill_ff <= fill_in;
         len_ff <= len_in;
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
         rnd_ff <= rnd_in;
         cv_ff <= cv_in;
      end
   end

   // Payload registers: block buffer, round state, schedule window.
   always_ff @(posedge clock) begin
      st_ff <= st_in;
      w_ff <= w_in;
      if (cmd.load_word) begin
         word_ff <= req_data_word;
         last_ff <= req_last_word;
      end
      if (cmd.put_data || cmd.put_pad) begin
         blk_ff[widx] <= (blk_ff[widx] & ~(32'hFF << wsh))
            | ({24'd0, cmd.put_pad ? wbyte : word_ff[31 - 8*pos_ff -: 8]} << wsh);
      end
      if (cmd.clear_blk) begin
         for (int i = 0; i < 16; i++) blk_ff[i] <= 32'd0;
      end
      if (cmd.put_len) begin
         blk_ff[14] <= len_ff[63:32];
         blk_ff[15] <= len_ff[31:0];
      end
   end

   always_comb begin
      sts.bytes_left = (cnt_ff != 3'd0);
      sts.fill = fill_ff;
      sts.last_round = (rnd_ff == 6'd63);
      sts.last_flag = last_ff;
      digest_out = cv_ff[cmd.emit_idx];
   end
endmodule
`default_nettype wire

FILE: src/sm3_ctrl.sv
// SM3 controller: sequences packing, padding, compression and digest output.
`default_nettype none
module sm3_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output logic [2:0]               rsp_word_index,
   output logic                     rsp_digest_done,
   input  wire sm3_pkg::dp_sts_type sts,
   output sm3_pkg::dp_cmd_type      cmd
);
   import sm3_pkg::*;

   ctrl_state_type state_ff, state_in;
   // Pad phase: 0 = first pad byte, 1 = zeros.
   logic       padz_ff, padz_in;
   logic       extra_ff, extra_in;   // compressing a padding block that needs another
   logic       fin_ff, fin_in;       // compressing the final block
   logic [2:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         padz_ff <= 1'b0;
         extra_ff <= 1'b0;
         fin_ff <= 1'b0;
         idx_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         padz_ff <= padz_in;
         extra_ff <= extra_in;
         fin_ff <= fin_in;
         idx_ff <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      padz_in = padz_ff;
      extra_in = extra_ff;
      fin_in = fin_ff;
      idx_in = idx_ff;
      cmd = '0;
      cmd.emit_idx = idx_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_word = 1'b1;
               state_in = ST_PACK;
            end
         end
         ST_PACK: begin
            if (sts.bytes_left) begin
               cmd.put_data = 1'b1;
               // Fill about to wrap: the block is full after this byte.
               if (sts.fill == 6'd63) begin
                  state_in = ST_LOAD;
                  fin_in = 1'b0;
                  extra_in = 1'b0;
               end
            end else if (sts.last_flag) begin
               state_in = ST_PAD;
               padz_in = 1'b0;
               extra_in = (sts.fill >= 6'd56);
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            // Write 0x80 then zeros up to the end of the block.
            cmd.put_pad = 1'b1;
            cmd.pad_mark = !padz_ff;
            padz_in = 1'b1;
            if (sts.fill == 6'd63) begin
               if (extra_ff) begin
                  state_in = ST_LOAD;
                  fin_in = 1'b0;
               end else begin
                  state_in = ST_LEN;
               end
            end
         end
         ST_LEN: begin
            // The length words close the final block.
            cmd.put_len = 1'b1;
            fin_in = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.comp_start = 1'b1;
            state_in = ST_COMP;
         end
         ST_COMP: begin
            cmd.comp_round = 1'b1;
            if (sts.last_round) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.comp_final = 1'b1;
            if (fin_ff) begin
               state_in = ST_EMIT;
               idx_in = 3'd0;
            end else if (extra_ff) begin
               extra_in = 1'b0;
               cmd.clear_blk = 1'b1;
               state_in = ST_LEN;
            end else begin
               state_in = ST_PACK;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.reinit = 1'b1;
                  fin_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_word_index = idx_ff;
   assign rsp_digest_done = (idx_ff == 3'd7);
endmodule
`default_nettype wire

FILE: src/sm3_hash_engine_unit.sv
// Top level of the SM3 hash engine.
//
//  channel  direction  payload
//  req      in         data_word[31:0], valid_bytes[2:0], last_word
//  rsp      out        digest_word[31:0], word_index[2:0], digest_done
//
// A word is accepted while idle, its valid bytes are packed one at a time, then it finishes.
// Each full block adds one load, 64 rounds (one per cycle) and one fold.
// A last word adds the padding bytes, a length step, one or two
// compressions, and eight digest word transfers.
// Synchronous reset returns the chaining value to the SM3 initial value.
// Input is taken only when idle; a waiting digest word stalls the whole engine.
`default_nettype none
module sm3_hash_engine_unit (
   input wire clock,
   input wire reset,
   sm3_req_if.sink   req,
   sm3_rsp_if.source rsp
);
   import sm3_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   sm3_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_word_index(rsp.word_index), .rsp_digest_done(rsp.digest_done),
      .sts(sts), .cmd(cmd)
   );

   sm3_datapath u_dp (
      .clock(clock), .reset(reset),
      .req_data_word(req.data_word), .req_valid_bytes(req.valid_bytes),
      .req_last_word(req.last_word),
      .cmd(cmd), .sts(sts), .digest_out(rsp.digest_word)
   );
endmodule
`default_nettype wire

FILE: src/sm3_hash_engine_unit_chk.sv
// Port-level checker for the SM3 hash engine, bound to the top level.
`include "sm3_hash_engine_unit_macros.svh"
`default_nettype none
module sm3_hash_engine_unit_chk (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [2:0] rsp_word_index,
   input wire       rsp_digest_done
);
   // Done flag marks exactly the eighth word.
   `SM3_ASSERT_IMPL(a_done_idx, clock, reset, rsp_valid, rsp_digest_done == (rsp_word_index == 3'd7))
   // No input taken while a digest is offered.
   `SM3_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   // Digest words advance in order.
   `SM3_ASSERT_NEXT(a_idx_step, clock, reset, rsp_valid && rsp_ready && !rsp_digest_done, rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
   // A stalled word stays offered.
   `SM3_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word_index))
endmodule

bind sm3_hash_engine_unit sm3_hash_engine_unit_chk u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_word_index(rsp.word_index), .rsp_digest_done(rsp.digest_done)
);
`default_nettype wire
